/* rtl/tht_pkg.sv */
// Package for the tagged handle table: default sizes, operation and status
// codes, and the sequencer state type.
// No dependencies; used by tagged_handle_table_top.
`timescale 1ns / 1ps

package tht_pkg;

    localparam int INDEX_BITS_DEF = 14;
    localparam int TAG_WIDTH_DEF  = 18;
    localparam int KIND_BITS_DEF  = 5;
    localparam int COUNT_BITS_DEF = 9;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int KIND_IN_W = 5;
    localparam int HANDLE_W  = 32;
    localparam int STATUS_W  = 4;
    localparam int REF_W     = 9;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_FIND    = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATED   = 4'd0,
        ST_REUSED    = 4'd1,
        ST_FOUND     = 4'd2,
        ST_NOT_FOUND = 4'd3,
        ST_HELD      = 4'd4,
        ST_LAST      = 4'd5,
        ST_STALE     = 4'd6,
        ST_FULL      = 4'd7,
        ST_LIMIT     = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL_RD,
        S_REL_LAT,
        S_FINISH
    } t_state;

endpackage

/* rtl/tht_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tagged_handle_table_top.sv */
// Tagged handle table: reference-counted entries in one RAM, searched by a
// sequencer one entry per cycle.
// Depends on tht_pkg and tht_ram.
//
//   channel   direction   handshake                     payload
//   input     in          i_in_valid / o_in_ready       i_op i_key i_kind i_handle_in
//   result    out         o_out_valid / i_out_ready     o_handle_out o_status o_ref_count
//
// An acquire or find reads the entries up to highest_used in order and stops
// early on a match; a release reads the one entry its handle names, and an
// undefined operation goes straight to the final step. o_in_ready returns
// once the final step hands its result to the output register.
// After reset a clearing pass writes every entry to zero, and no item is
// accepted until it ends. One item is worked at a time; a result stalled
// on the output holds the next item in its final step.
`timescale 1ns / 1ps

module tagged_handle_table_top #(
    parameter int INDEX_BITS = tht_pkg::INDEX_BITS_DEF,
    parameter int TAG_WIDTH  = tht_pkg::TAG_WIDTH_DEF,
    parameter int KIND_BITS  = tht_pkg::KIND_BITS_DEF,
    parameter int COUNT_BITS = tht_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tht_pkg::OP_W-1:0]      i_op,
    input  logic [tht_pkg::KEY_W-1:0]     i_key,
    input  logic [tht_pkg::KIND_IN_W-1:0] i_kind,
    input  logic [tht_pkg::HANDLE_W-1:0]  i_handle_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tht_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic [tht_pkg::STATUS_W-1:0]  o_status,
    output logic [tht_pkg::REF_W-1:0]     o_ref_count
);

    localparam int TABLE_SIZE = 1 << INDEX_BITS;
    localparam int HU_W       = INDEX_BITS + 1;
    localparam int COUNT_LO   = 0;
    localparam int KIND_LO    = COUNT_BITS;
    localparam int TAG_LO     = KIND_LO + KIND_BITS;
    localparam int KEY_LO     = TAG_LO + TAG_WIDTH;
    localparam int ENTRY_W    = KEY_LO + tht_pkg::KEY_W;

    localparam logic [TAG_WIDTH-1:0]  TAG_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    tht_pkg::t_state                 r_state, n_state;
    logic [tht_pkg::OP_W-1:0]        r_op, n_op;
    logic [tht_pkg::KEY_W-1:0]       r_key, n_key;
    logic [KIND_BITS-1:0]            r_kind, n_kind;
    logic [tht_pkg::HANDLE_W-1:0]    r_hin, n_hin;
    logic [HU_W-1:0]                 r_ptr, n_ptr;
    logic                            r_pv, n_pv;
    logic [INDEX_BITS-1:0]           r_pidx, n_pidx;
    logic                            r_hit, n_hit;
    logic [INDEX_BITS-1:0]           r_hidx, n_hidx;
    logic [ENTRY_W-1:0]              r_ent, n_ent;
    logic                            r_free_ok, n_free_ok;
    logic [INDEX_BITS-1:0]           r_free_idx, n_free_idx;
    logic [HU_W-1:0]                 r_hu, n_hu;
    logic [TAG_WIDTH-1:0]            r_tag, n_tag;
    logic                            r_ovalid, n_ovalid;
    logic [tht_pkg::HANDLE_W-1:0]    r_handle, n_handle;
    tht_pkg::t_status                r_status, n_status;
    logic [tht_pkg::REF_W-1:0]       r_count, n_count;

    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [INDEX_BITS-1:0] ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    tht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Fields of the entry coming out of the RAM and of the latched entry.
    logic [tht_pkg::KEY_W-1:0] rd_key, ent_key;
    logic [TAG_WIDTH-1:0]      rd_tag, ent_tag;
    logic [KIND_BITS-1:0]      rd_kind, ent_kind;
    logic [COUNT_BITS-1:0]     ent_cnt;

    assign rd_key   = ram_rdata[KEY_LO +: tht_pkg::KEY_W];
    assign rd_tag   = ram_rdata[TAG_LO +: TAG_WIDTH];
    assign rd_kind  = ram_rdata[KIND_LO +: KIND_BITS];
    assign ent_key  = r_ent[KEY_LO +: tht_pkg::KEY_W];
    assign ent_tag  = r_ent[TAG_LO +: TAG_WIDTH];
    assign ent_kind = r_ent[KIND_LO +: KIND_BITS];
    assign ent_cnt  = r_ent[COUNT_LO +: COUNT_BITS];

    logic                         issue, match;
    logic [TAG_WIDTH-1:0]         tag_next;
    logic [INDEX_BITS-1:0]        new_idx;
    logic                         full;
    logic [tht_pkg::HANDLE_W-1:0] hit_handle, new_handle;
    logic [31:0]                  hin_tag32;
    logic                         stale;

    assign issue = r_ptr < r_hu;
    assign match = r_pv && (rd_tag != '0) && (rd_key == r_key) && (rd_kind == r_kind);

    assign tag_next   = (r_tag == TAG_MAX) ? TAG_WIDTH'(1) : r_tag + 1'b1;
    // Slots at or above highest_used have never been stamped, so the first
    // of them is free whenever the scan found no hole below it.
    assign new_idx    = r_free_ok ? r_free_idx : r_hu[INDEX_BITS-1:0];
    assign full       = !r_free_ok && r_hu[INDEX_BITS];
    assign hit_handle = tht_pkg::HANDLE_W'((64'(ent_tag) << INDEX_BITS) | 64'(r_hidx));
    assign new_handle = tht_pkg::HANDLE_W'((64'(tag_next) << INDEX_BITS) | 64'(new_idx));

    // A zero tag or one that is wider than TAG_WIDTH can never equal a stored tag.
    assign hin_tag32  = 32'(r_hin >> INDEX_BITS);
    assign stale      = (hin_tag32 == 32'd0) || (32'(ent_tag) != hin_tag32)
                        || (ent_kind != r_kind);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_kind     = r_kind;
        n_hin      = r_hin;
        n_ptr      = r_ptr;
        n_pv       = r_pv;
        n_pidx     = r_pidx;
        n_hit      = r_hit;
        n_hidx     = r_hidx;
        n_ent      = r_ent;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_hu       = r_hu;
        n_tag      = r_tag;
        n_ovalid   = r_ovalid;
        n_handle   = r_handle;
        n_status   = r_status;
        n_count    = r_count;
        ram_we     = 1'b0;
        ram_waddr  = new_idx;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_ptr[INDEX_BITS-1:0];
        o_in_ready = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            tht_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[INDEX_BITS-1:0];
                if (r_ptr[INDEX_BITS-1:0] == '1) begin
                    n_ptr   = '0;
                    n_state = tht_pkg::S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            tht_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op      = i_op;
                    n_key     = i_key;
                    n_kind    = KIND_BITS'(i_kind);
                    n_hin     = i_handle_in;
                    n_ptr     = '0;
                    n_pv      = 1'b0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    case (i_op)
                        tht_pkg::OP_ACQUIRE: n_state = tht_pkg::S_SCAN;
                        tht_pkg::OP_FIND:    n_state = tht_pkg::S_SCAN;
                        tht_pkg::OP_RELEASE: n_state = tht_pkg::S_REL_RD;
                        default:             n_state = tht_pkg::S_FINISH;
                    endcase
                end
            end

            tht_pkg::S_SCAN: begin
                // Each read is compared in the cycle after it is issued.
                if (match) begin
                    n_hit   = 1'b1;
                    n_hidx  = r_pidx;
                    n_ent   = ram_rdata;
                    n_pv    = 1'b0;
                    n_state = tht_pkg::S_FINISH;
                end else begin
                    if (r_pv && (rd_tag == '0) && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_pidx;
                    end
                    if (issue) begin
                        ram_re = 1'b1;
                        n_ptr  = r_ptr + 1'b1;
                        n_pv   = 1'b1;
                        n_pidx = r_ptr[INDEX_BITS-1:0];
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv) begin
                            n_state = tht_pkg::S_FINISH;
                        end
                    end
                end
            end

            tht_pkg::S_REL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_hin[INDEX_BITS-1:0];
                n_state   = tht_pkg::S_REL_LAT;
            end

            tht_pkg::S_REL_LAT: begin
                n_ent   = ram_rdata;
                n_hidx  = r_hin[INDEX_BITS-1:0];
                n_state = tht_pkg::S_FINISH;
            end

            tht_pkg::S_FINISH: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_state  = tht_pkg::S_IDLE;
                    n_handle = '0;
                    n_count  = '0;
                    n_status = tht_pkg::ST_NOT_FOUND;
                    case (r_op)
                        tht_pkg::OP_ACQUIRE: begin
                            if (r_hit) begin
                                if (ent_cnt == COUNT_MAX) begin
                                    n_status = tht_pkg::ST_LIMIT;
                                    n_count  = tht_pkg::REF_W'(ent_cnt);
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_hidx;
                                    ram_wdata = {ent_key, ent_tag, ent_kind, ent_cnt + 1'b1};
                                    n_status  = tht_pkg::ST_REUSED;
                                    n_handle  = hit_handle;
                                    n_count   = tht_pkg::REF_W'(ent_cnt + 1'b1);
                                end
                            end else if (full) begin
                                n_status = tht_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = new_idx;
                                ram_wdata = {r_key, tag_next, r_kind, COUNT_BITS'(1)};
                                n_tag     = tag_next;
                                if (HU_W'(new_idx) >= r_hu) begin
                                    n_hu = HU_W'(new_idx) + 1'b1;
                                end
                                n_status  = tht_pkg::ST_CREATED;
                                n_handle  = new_handle;
                                n_count   = tht_pkg::REF_W'(1);
                            end
                        end
                        tht_pkg::OP_RELEASE: begin
                            ram_waddr = r_hidx;
                            if (stale) begin
                                n_status = tht_pkg::ST_STALE;
                            end else if (ent_cnt > COUNT_BITS'(1)) begin
                                ram_we    = 1'b1;
                                ram_wdata = {ent_key, ent_tag, ent_kind, ent_cnt - 1'b1};
                                n_status  = tht_pkg::ST_HELD;
                                n_handle  = hit_handle;
                                n_count   = tht_pkg::REF_W'(ent_cnt - 1'b1);
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = '0;
                                n_status  = tht_pkg::ST_LAST;
                                n_handle  = hit_handle;
                            end
                        end
                        tht_pkg::OP_FIND: begin
                            if (r_hit) begin
                                n_status = tht_pkg::ST_FOUND;
                                n_handle = hit_handle;
                                n_count  = tht_pkg::REF_W'(ent_cnt);
                            end
                        end
                        default: begin
                            n_status = tht_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            default: begin
                n_state = tht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tht_pkg::S_CLEAR;
            r_ptr     <= '0;
            r_pv      <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_hu      <= '0;
            r_tag     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_pv      <= n_pv;
            r_hit     <= n_hit;
            r_free_ok <= n_free_ok;
            r_hu      <= n_hu;
            r_tag     <= n_tag;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_kind     <= n_kind;
        r_hin      <= n_hin;
        r_pidx     <= n_pidx;
        r_hidx     <= n_hidx;
        r_ent      <= n_ent;
        r_free_idx <= n_free_idx;
        r_handle   <= n_handle;
        r_status   <= n_status;
        r_count    <= n_count;
    end

    assign o_out_valid  = r_ovalid;
    assign o_handle_out = r_handle;
    assign o_status     = r_status;
    assign o_ref_count  = r_count;

    // A result only appears from the final step of an item.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == tht_pkg::S_FINISH))
        else $error("result raised outside the final step");

    // No result may be pending while the table is still being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tht_pkg::S_CLEAR) |-> !r_ovalid)
        else $error("result valid during clearing pass");

    // Successful lookups always carry a handle with a non-zero tag.
    a_success_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status == tht_pkg::ST_CREATED || r_status == tht_pkg::ST_REUSED
                      || r_status == tht_pkg::ST_FOUND)) |-> (r_handle != '0))
        else $error("successful transfer with zero handle");

    // Failures return a zero handle.
    a_failure_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status == tht_pkg::ST_STALE || r_status == tht_pkg::ST_FULL
                      || r_status == tht_pkg::ST_LIMIT || r_status == tht_pkg::ST_NOT_FOUND))
        |-> (r_handle == '0))
        else $error("failed transfer with non-zero handle");

    // The high-water mark never passes the table size.
    a_hu_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hu <= HU_W'(TABLE_SIZE))
        else $error("highest_used beyond table size");

endmodule
